>>> hdl/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types and constants for the signed integer to radix text core.
// ----------------------------------------------------------------------------
package sirt_pkg;

	localparam int VALUE_W      = 32;
	localparam int BYTE_W       = 8;
	localparam int RADIX_W      = 6;
	localparam int SYM_REG_W    = 64;
	localparam int NUM_SYM_REGS = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int MAX_RADIX    = 32;
	localparam int MAX_DIGITS   = 32;
	localparam int DIGIT_W      = 5;
	localparam int DIGIT_ADDR_W = 5;
	localparam int COUNT_W      = 6;

	localparam int DIV_BITS   = 8;
	localparam int DIV_CHUNKS = VALUE_W / DIV_BITS;
	localparam int CHUNK_W    = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [BYTE_W-1:0]  SYM_PLUS      = 8'd43;
	localparam logic [BYTE_W-1:0]  SYM_MINUS     = 8'd45;
	localparam logic [BYTE_W-1:0]  SYM_NEWLINE   = 8'd10;
	localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX        = 3'd0,
		REG_SYM_LOW      = 3'd1,
		REG_SYM_MID_LOW  = 3'd2,
		REG_SYM_MID_HIGH = 3'd3,
		REG_SYM_HIGH     = 3'd4
	} reg_idx_t;

	typedef logic [MAX_RADIX-1:0][BYTE_W-1:0] sym_table_t;

	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		sym_table_t         symbols;
	} cfg_t;

	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} item_t;

	typedef struct packed {
		logic  push;
		item_t item;
	} q_wr_t;

	typedef struct packed {
		logic  full;
		logic  empty;
		item_t head;
	} q_stat_t;

endpackage

>>> hdl/signed_int_to_radix_text_core.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_core
// Signed 32-bit integer to text in a configurable radix and symbol table.
// ----------------------------------------------------------------------------
// Each value taken on the item channel comes out on the text channel as an
// optional '-', the digit symbols most significant first and a newline marked
// last; with a bad alphabet (radix outside 2..32, or a used symbol that is
// zero, '+', '-' or repeated) the value is dropped and nothing is sent. The
// front can take a value every cycle while its two-entry queue has room. The
// back extracts the digits one by one (eight quotient bits a cycle through one
// restoring divider over the 32-bit magnitude), then sends each digit symbol
// from a registered output by a digit store read and then a load, which waits
// while the output is stalled; it takes the next value from the queue only
// once the newline is loaded.
module signed_int_to_radix_text_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic signed [sirt_pkg::VALUE_W-1:0]   value,
	output logic                                  text_valid,
	input  logic                                  text_stall,
	output logic [sirt_pkg::BYTE_W-1:0]           text_byte,
	output logic                                  last,
	input  logic                                  cfg_we,
	input  logic [sirt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [sirt_pkg::SYM_REG_W-1:0]        cfg_data
);
	import sirt_pkg::*;

	cfg_t    cfg;
	q_wr_t   q_wr;
	q_stat_t q_stat;
	logic    pop;

	sirt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.value      (value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.q_wr       (q_wr),
		.q_full     (q_stat.full)
	);

	sirt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.q_stat (q_stat)
	);

	sirt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_stat     (q_stat),
		.pop        (pop),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_byte  (text_byte),
		.last       (last)
	);

endmodule

>>> hdl/sirt_ram.sv
// ----------------------------------------------------------------------------
// sirt_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module sirt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> hdl/sirt_front.sv
// ----------------------------------------------------------------------------
// sirt_front
// Configuration registers, alphabet check and input classification.
// ----------------------------------------------------------------------------
module sirt_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic signed [sirt_pkg::VALUE_W-1:0]   value,
	input  logic                            cfg_we,
	input  logic [sirt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sirt_pkg::SYM_REG_W-1:0]  cfg_data,
	output sirt_pkg::cfg_t                  cfg,
	output sirt_pkg::q_wr_t                 q_wr,
	input  logic                            q_full
);
	import sirt_pkg::*;

	logic [RADIX_W-1:0]   radix_q;
	logic [SYM_REG_W-1:0] sym_q [NUM_SYM_REGS];
	sym_table_t           table_w;
	logic                 alpha_ok_q;
	logic                 alpha_ok;
	logic                 radix_ok;
	logic [MAX_RADIX-1:0] used;
	logic                 bad;

	logic                 valid_s1;
	logic [VALUE_W-1:0]   value_s1;
	logic                 advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			for (int i = 0; i < NUM_SYM_REGS; i++) begin
				sym_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIX:        radix_q  <= cfg_data[RADIX_W-1:0];
				REG_SYM_LOW:      sym_q[0] <= cfg_data;
				REG_SYM_MID_LOW:  sym_q[1] <= cfg_data;
				REG_SYM_MID_HIGH: sym_q[2] <= cfg_data;
				REG_SYM_HIGH:     sym_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign table_w     = {sym_q[3], sym_q[2], sym_q[1], sym_q[0]};
	assign cfg.radix   = radix_q;
	assign cfg.symbols = table_w;

	// alphabet check over the used symbols
	assign radix_ok = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);

	always_comb begin
		bad = 1'b0;
		for (int i = 0; i < MAX_RADIX; i++) begin
			used[i] = RADIX_W'(i) < radix_q;
		end
		for (int i = 0; i < MAX_RADIX; i++) begin
			if (used[i] && (table_w[i] == '0 || table_w[i] == SYM_PLUS ||
					table_w[i] == SYM_MINUS)) begin
				bad = 1'b1;
			end
			for (int j = i + 1; j < MAX_RADIX; j++) begin
				if (used[j] && table_w[i] == table_w[j]) begin
					bad = 1'b1;
				end
			end
		end
		alpha_ok = radix_ok && !bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_ok_q <= 1'b0;
		end else begin
			alpha_ok_q <= alpha_ok;
		end
	end

	// input stage: drop on a bad alphabet, otherwise queue sign and magnitude
	assign advance    = valid_s1 && (!alpha_ok_q || !q_full);
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			value_s1 <= value;
		end
	end

	assign q_wr.push     = valid_s1 && alpha_ok_q && !q_full;
	assign q_wr.item.neg = value_s1[VALUE_W-1];
	assign q_wr.item.mag = value_s1[VALUE_W-1] ? (~value_s1 + VALUE_W'(1)) : value_s1;

endmodule

>>> hdl/sirt_queue.sv
// ----------------------------------------------------------------------------
// sirt_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module sirt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  sirt_pkg::q_wr_t   q_wr,
	input  logic              pop,
	output sirt_pkg::q_stat_t q_stat
);
	import sirt_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign q_stat.full  = count_q == QCNT_W'(QUEUE_DEPTH);
	assign q_stat.empty = count_q == '0;
	assign q_stat.head  = mem_q[rd_ptr_q];

	assign do_push = q_wr.push && !q_stat.full;
	assign do_pop  = pop && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.item;
		end
	end

endmodule

>>> hdl/sirt_back.sv
// ----------------------------------------------------------------------------
// sirt_back
// Iterative digit extraction into the digit store, then text emission.
// ----------------------------------------------------------------------------
module sirt_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sirt_pkg::cfg_t               cfg,
	input  sirt_pkg::q_stat_t            q_stat,
	output logic                         pop,
	output logic                         text_valid,
	input  logic                         text_stall,
	output logic [sirt_pkg::BYTE_W-1:0]  text_byte,
	output logic                         last
);
	import sirt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_SIGN = 6'b000100,
		ST_RD   = 6'b001000,
		ST_LOAD = 6'b010000,
		ST_NL   = 6'b100000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [VALUE_W-1:0] mag_q;
	logic [DIGIT_W-1:0] rem_q;
	logic [CHUNK_W-1:0] chunk_q;
	logic [COUNT_W-1:0] count_q;
	logic               neg_q;

	logic [DIV_BITS-1:0] qbits;
	logic [DIGIT_W-1:0]  rem_next;
	logic [DIGIT_W:0]    trial;
	logic [VALUE_W-1:0]  mag_next;
	logic                last_chunk;

	logic                wr_en;
	logic                rd_en;
	logic [DIGIT_W-1:0]  rd_data;
	logic [COUNT_W-1:0]  rd_index;

	logic                out_valid_q;
	logic [BYTE_W-1:0]   text_byte_q;
	logic                last_q;
	logic                out_free;
	logic                load;
	logic [BYTE_W-1:0]   load_byte;
	logic                load_last;

	// eight restoring steps a cycle on a narrow remainder
	always_comb begin
		rem_next = rem_q;
		qbits    = '0;
		trial    = '0;
		for (int b = 0; b < DIV_BITS; b++) begin
			trial = {rem_next, mag_q[VALUE_W-1-b]};
			if (trial >= cfg.radix) begin
				qbits[DIV_BITS-1-b] = 1'b1;
				trial = trial - cfg.radix;
			end
			rem_next = trial[DIGIT_W-1:0];
		end
	end

	assign mag_next   = {mag_q[VALUE_W-DIV_BITS-1:0], qbits};
	assign last_chunk = chunk_q == CHUNK_W'(DIV_CHUNKS - 1);
	assign out_free   = !out_valid_q || !text_stall;
	assign rd_index   = count_q - COUNT_W'(1);

	assign wr_en = (state_q == ST_DIV) && last_chunk;
	assign rd_en = state_q == ST_RD;
	assign pop   = (state_q == ST_IDLE) && !q_stat.empty;

	sirt_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digit_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[DIGIT_ADDR_W-1:0]),
		.wr_data (rem_next),
		.rd_en   (rd_en),
		.rd_addr (rd_index[DIGIT_ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		load_byte = SYM_NEWLINE;
		load_last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (last_chunk && mag_next == '0) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				if (!neg_q) begin
					state_d = ST_RD;
				end else if (out_free) begin
					load      = 1'b1;
					load_byte = SYM_MINUS;
					state_d   = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free) begin
					load      = 1'b1;
					load_byte = cfg.symbols[rd_data];
					state_d   = (count_q == COUNT_W'(1)) ? ST_NL : ST_RD;
				end
			end
			ST_NL: begin
				if (out_free) begin
					load      = 1'b1;
					load_byte = SYM_NEWLINE;
					load_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			chunk_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					count_q <= '0;
					chunk_q <= '0;
				end
				ST_DIV: begin
					chunk_q <= last_chunk ? '0 : chunk_q + CHUNK_W'(1);
					if (last_chunk) begin
						count_q <= count_q + COUNT_W'(1);
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						count_q <= count_q - COUNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mag_q <= q_stat.head.mag;
				neg_q <= q_stat.head.neg;
				rem_q <= '0;
			end
			ST_DIV: begin
				mag_q <= mag_next;
				rem_q <= last_chunk ? '0 : rem_next;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!text_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			text_byte_q <= load_byte;
			last_q      <= load_last;
		end
	end

	assign text_valid = out_valid_q;
	assign text_byte  = text_byte_q;
	assign last       = last_q;

endmodule

>>> hdl/sirt_checker.sv
// ----------------------------------------------------------------------------
// sirt_checker
// Port-level checks on the text channel of the radix text core.
// ----------------------------------------------------------------------------
module sirt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         text_valid,
	input logic                         text_stall,
	input logic [sirt_pkg::BYTE_W-1:0]  text_byte,
	input logic                         last
);
	import sirt_pkg::*;

	// stalled transaction holds
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_stall |=> text_valid && $stable(text_byte) && $stable(last))
		else $error("text transaction changed while stalled");

	// only the newline closes a number
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && last |-> text_byte == SYM_NEWLINE)
		else $error("last set on a byte other than newline");

	// sign and digit symbols are never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !last |-> text_byte != '0)
		else $error("zero byte emitted before the newline");

	// a sign is followed by a digit, never by another sign
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_stall && text_byte == SYM_MINUS
		|=> !(text_valid && text_byte == SYM_MINUS))
		else $error("two signs in a row");

	// numbers cannot end on consecutive cycles
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_stall && last |=> !(text_valid && last))
		else $error("two newlines on consecutive cycles");

endmodule

bind signed_int_to_radix_text_core sirt_checker u_sirt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.text_valid (text_valid),
	.text_stall (text_stall),
	.text_byte  (text_byte),
	.last       (last)
);
